/* rtl/siowdt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the Super I/O watchdog configuration port.
// No dependencies.
package siowdt_pkg;

    localparam logic [7:0] KEY_ENTER = 8'h87;
    localparam logic [7:0] KEY_EXIT  = 8'hAA;
    localparam logic [7:0] REG_LDN   = 8'h07;
    localparam logic [7:0] LDN_WDT   = 8'h08;
    localparam logic [7:0] REG_ACT   = 8'h30;
    localparam logic [7:0] REG_WDCNT = 8'hF6;
    localparam logic [7:0] RD_IDLE   = 8'hFF;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KEY_LOCKED = 3'b001,
        KEY_HALF   = 3'b010,
        KEY_OPEN   = 3'b100
    } key_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic       port_sel;
        logic [7:0] wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       unlocked;
        logic [7:0] count_now;
        logic       fire;
    } result_t;

endpackage

/* rtl/siowdt_in_reg.sv */
`timescale 1ns / 1ps
// Input register stage: holds one accepted bus access or tick.
// Depends on siowdt_pkg.
module siowdt_in_reg
    import siowdt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t item_in,
    input  logic  advance,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

/* rtl/siowdt_state.sv */
`timescale 1ns / 1ps
// Key sequence, register file and watchdog counter; forms one result per item.
// Depends on siowdt_pkg.
module siowdt_state
    import siowdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    key_state_t key_reg,    key_next;
    logic [7:0] index_reg,  index_next;
    logic [7:0] ldn_reg,    ldn_next;
    logic       active_reg, active_next;
    logic [7:0] count_reg,  count_next;
    logic       fired_reg,  fired_next;
    logic [7:0] rdata;
    logic       is_open;
    logic       wdt_sel;

    assign is_open = (key_reg == KEY_OPEN);
    assign wdt_sel = (ldn_reg == LDN_WDT);

    always_comb
    begin
        key_next    = key_reg;
        index_next  = index_reg;
        ldn_next    = ldn_reg;
        active_next = active_reg;
        count_next  = count_reg;
        fired_next  = fired_reg;
        rdata       = RD_IDLE;
        unique case (action_t'(item.action))
            ACT_WRITE:
            begin
                if (!item.port_sel)
                begin
                    if (is_open)
                    begin
                        if (item.wdata == KEY_EXIT)
                            key_next = KEY_LOCKED;
                        else
                            index_next = item.wdata;
                    end
                    else if (item.wdata == KEY_ENTER)
                        key_next = (key_reg == KEY_HALF) ? KEY_OPEN : KEY_HALF;
                    else
                        key_next = KEY_LOCKED;
                end
                else if (is_open)
                begin
                    if (index_reg == REG_LDN)
                        ldn_next = item.wdata;
                    else if (wdt_sel && index_reg == REG_ACT)
                        active_next = item.wdata[0];
                    else if (wdt_sel && index_reg == REG_WDCNT)
                        count_next = item.wdata;
                end
            end
            ACT_READ:
            begin
                if (is_open)
                begin
                    if (!item.port_sel)
                        rdata = index_reg;
                    else if (index_reg == REG_LDN)
                        rdata = ldn_reg;
                    else if (wdt_sel && index_reg == REG_ACT)
                        rdata = {7'd0, active_reg};
                    else if (wdt_sel && index_reg == REG_WDCNT)
                        rdata = count_reg;
                end
            end
            ACT_TICK:
            begin
                if (active_reg && count_reg != 8'd0)
                begin
                    count_next = count_reg - 8'd1;
                    if (count_reg == 8'd1)
                        fired_next = 1'b1;
                end
            end
            ACT_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= KEY_LOCKED;
            index_reg  <= 8'd0;
            ldn_reg    <= 8'd0;
            active_reg <= 1'b0;
            count_reg  <= 8'd0;
            fired_reg  <= 1'b0;
        end
        else if (advance)
        begin
            key_reg    <= key_next;
            index_reg  <= index_next;
            ldn_reg    <= ldn_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            fired_reg  <= fired_next;
        end
    end

    assign result.rdata     = rdata;
    assign result.unlocked  = (key_next == KEY_OPEN);
    assign result.count_now = count_next;
    assign result.fire      = fired_next;

endmodule

/* rtl/siowdt_out_reg.sv */
`timescale 1ns / 1ps
// Result register: holds one result until the consumer takes it.
// Depends on siowdt_pkg.
module siowdt_out_reg
    import siowdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  result_t result_in,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = item_valid && (!valid_reg || !out_stall);
    assign valid_next = advance ? 1'b1 : (out_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

/* rtl/superio_watchdog_config_port_core.sv */
`timescale 1ns / 1ps
// Top level of the Super I/O configuration port with seconds watchdog.
// Depends on siowdt_pkg, siowdt_in_reg, siowdt_state, siowdt_out_reg.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  input   | in_valid / in_stall | action, port_sel, wdata
//  output  | out_valid/out_stall | rdata, unlocked, count_now, fire
//
// One transfer per cycle in each direction while neither side stalls; the result becomes
// valid once the item has moved through the input register into the result register.
// State updates as an item moves into the result register.
// Reset clears the key sequence, registers, counter and fire flag.
// Output stall backs up through in_stall in the same cycle once both stages hold.
module superio_watchdog_config_port_core
    import siowdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic       port_sel,
    input  logic [7:0] wdata,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] rdata,
    output logic       unlocked,
    output logic [7:0] count_now,
    output logic       fire
);

    item_t   item_in;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t result_out;

    assign item_in.action   = action;
    assign item_in.port_sel = port_sel;
    assign item_in.wdata    = wdata;

    siowdt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    siowdt_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    siowdt_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result_in  (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_out)
    );

    assign rdata     = result_out.rdata;
    assign unlocked  = result_out.unlocked;
    assign count_now = result_out.count_now;
    assign fire      = result_out.fire;

endmodule

/* rtl/siowdt_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the watchdog configuration port, with its bind.
// Depends on siowdt_pkg and superio_watchdog_config_port_core.
module siowdt_chk
    import siowdt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] rdata,
    input logic       unlocked,
    input logic [7:0] count_now,
    input logic       fire
);

    logic fire_seen_reg;
    logic fire_seen_next;

    assign fire_seen_next = fire_seen_reg || (out_valid && !out_stall && fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_seen_reg <= 1'b0;
        end
        else
        begin
            fire_seen_reg <= fire_seen_next;
        end
    end

    // fire is sticky across transfers
    a_fire_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire_seen_reg |-> fire)
        else $error("fire dropped after being reported");

    // first fire only with an expired counter
    a_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire && !fire_seen_reg |-> count_now == 8'd0)
        else $error("fire raised with nonzero counter");

    a_locked_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unlocked |-> rdata == RD_IDLE)
        else $error("read data shown while locked");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rdata) && $stable(count_now))
        else $error("stalled result changed");

endmodule

bind superio_watchdog_config_port_core siowdt_chk u_siowdt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .unlocked  (unlocked),
    .count_now (count_now),
    .fire      (fire)
);
